// File: rtl/ptw_pkg.sv
package ptw_pkg;

    // Default sizes of the wheel.
    localparam int WHEEL_SLOTS_DEF = 16;
    localparam int MAX_TIMERS_DEF  = 32;
    localparam int PERIOD_BITS_DEF = 16;

    // Fixed field widths of the request and result channels.
    localparam int ACTION_BITS = 2;
    localparam int ID_BITS     = 5;
    localparam int PERIOD_IN_BITS = 16;
    localparam int KIND_BITS   = 3;

    localparam logic [ACTION_BITS-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_DEL  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_TICK = 2'd2;

    localparam logic [KIND_BITS-1:0] KIND_ADDED    = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_DELETED  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_DEL_MISS = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_FIRED    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_IDLE_TICK = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADD_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/ptw_ram.sv
module ptw_ram #(
    parameter  int WIDTH     = 8,
    parameter  int DEPTH     = 32,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/periodic_timer_wheel_unit.sv
// Add: ST_DIV does the reciprocal multiply that gives the round count, then ST_ADD_WR writes
// the entry and registers the result. Delete: result valid in the cycle after the request.
// Tick: ST_SCAN reads every entry of the entry RAM, ST_DRAIN finishes the last write-back, then
// ST_EMIT walks the fired ids, one result each (an idle-tick result if none fired), and waits
// while the output stalls. One request is in work at a time; the next is taken once idle and
// the output register is empty or being read. Synchronous reset.
module periodic_timer_wheel_unit #(
    parameter int WHEEL_SLOTS = ptw_pkg::WHEEL_SLOTS_DEF,
    parameter int MAX_TIMERS  = ptw_pkg::MAX_TIMERS_DEF,
    parameter int PERIOD_BITS = ptw_pkg::PERIOD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ptw_pkg::ACTION_BITS-1:0]     s_action,
    input  logic [ptw_pkg::ID_BITS-1:0]         s_timer_id,
    input  logic [ptw_pkg::PERIOD_IN_BITS-1:0]  s_period,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ptw_pkg::KIND_BITS-1:0]       m_kind,
    output logic [ptw_pkg::ID_BITS-1:0]         m_timer_id_res,
    output logic                                m_last
);

    localparam int SLOT_BITS  = $clog2(WHEEL_SLOTS);
    localparam int FLOOR_LOG  = $clog2(WHEEL_SLOTS + 1) - 1;
    localparam int ROUND_BITS = (PERIOD_BITS > FLOOR_LOG) ? PERIOD_BITS - FLOOR_LOG : 1;
    localparam int IDX_BITS   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    // Scaled reciprocal of the slot count; exact for every dividend below 2**PERIOD_BITS.
    localparam int RECIP_SHIFT = PERIOD_BITS + SLOT_BITS;
    localparam int RECIP_BITS  = PERIOD_BITS + 2;
    localparam int PROD_BITS   = PERIOD_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
        ((64'd1 << RECIP_SHIFT) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS));

    localparam logic [SLOT_BITS:0]    SLOTS_W   = (SLOT_BITS + 1)'(WHEEL_SLOTS);
    localparam logic [SLOT_BITS-1:0]  SLOT_TOP  = SLOT_BITS'(WHEEL_SLOTS - 1);
    localparam logic [IDX_BITS-1:0]   IDX_TOP   = IDX_BITS'(MAX_TIMERS - 1);
    localparam logic [MAX_TIMERS-1:0] TIMER_ONE = MAX_TIMERS'(1);

    // offset is period mod slots; reload is the round count used on every re-arm.
    typedef struct packed {
        logic [SLOT_BITS-1:0]  offset;
        logic [ROUND_BITS-1:0] reload;
        logic [ROUND_BITS-1:0] rounds;
        logic [SLOT_BITS-1:0]  slot;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    ptw_pkg::state_t state_reg, state_next;

    logic [MAX_TIMERS-1:0]          valid_reg, valid_next;
    logic [SLOT_BITS-1:0]           pos_reg, pos_next;
    logic [ptw_pkg::ID_BITS-1:0]    id_reg, id_next;
    logic [PERIOD_BITS-1:0]         div_x_reg, div_x_next;
    logic [ROUND_BITS-1:0]          div_q_reg, div_q_next;
    logic [IDX_BITS-1:0]            rd_idx_reg, rd_idx_next;
    logic                           pipe_vld_reg, pipe_vld_next;
    logic [IDX_BITS-1:0]            pipe_idx_reg, pipe_idx_next;
    logic [MAX_TIMERS-1:0]          fired_reg, fired_next;
    logic [IDX_BITS-1:0]            emit_idx_reg, emit_idx_next;

    logic                           m_valid_reg, m_valid_next;
    logic [ptw_pkg::KIND_BITS-1:0]  m_kind_reg, m_kind_next;
    logic [ptw_pkg::ID_BITS-1:0]    m_id_reg, m_id_next;
    logic                           m_last_reg, m_last_next;

    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    entry_t                wr_entry;
    entry_t                rd_entry;
    logic [ENTRY_BITS-1:0] rd_word;

    logic                  out_free;
    logic                  accept;
    logic                  id_ok;
    logic [PERIOD_BITS-1:0] p_in;
    logic [PROD_BITS-1:0]  div_prod;
    logic [SLOT_BITS-1:0]  div_rem;
    logic [SLOT_BITS-1:0]  add_offset;
    logic                  hit;
    logic [MAX_TIMERS-1:0] fired_rest;
    logic                  emit_last;

    // Wraps position plus an offset (both below the slot count) back into the wheel.
    function automatic logic [SLOT_BITS-1:0] slot_after(
        input logic [SLOT_BITS-1:0] pos,
        input logic [SLOT_BITS-1:0] off
    );
        logic [SLOT_BITS:0] sum;
        sum = {1'b0, pos} + {1'b0, off};
        if (sum >= SLOTS_W) begin
            sum = sum - SLOTS_W;
        end
        return sum[SLOT_BITS-1:0];
    endfunction

    ptw_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_TIMERS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_word)
    );

    assign rd_entry = entry_t'(rd_word);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ptw_pkg::ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign id_ok    = 32'(s_timer_id) < MAX_TIMERS;
    assign p_in     = PERIOD_BITS'(s_period);

    // (period - 1) / slots by reciprocal multiplication; the remainder only needs the low bits.
    assign div_prod   = PROD_BITS'(div_x_reg) * PROD_BITS'(RECIP);
    assign div_rem    = SLOT_BITS'(div_x_reg) - SLOT_BITS'(div_q_reg) * SLOT_BITS'(WHEEL_SLOTS);
    assign add_offset = (div_rem == SLOT_TOP) ? '0 : div_rem + SLOT_BITS'(1);

    assign hit = pipe_vld_reg && valid_reg[pipe_idx_reg] && (rd_entry.slot == pos_reg);

    assign fired_rest = fired_reg & ~(TIMER_ONE << emit_idx_reg);
    assign emit_last  = (fired_rest == '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_action == ptw_pkg::ACT_ADD && id_ok) begin
                        state_next = ptw_pkg::ST_DIV;
                    end else if (s_action == ptw_pkg::ACT_TICK) begin
                        state_next = ptw_pkg::ST_SCAN;
                    end
                end
            end
            ptw_pkg::ST_DIV: begin
                state_next = ptw_pkg::ST_ADD_WR;
            end
            ptw_pkg::ST_ADD_WR: begin
                state_next = ptw_pkg::ST_IDLE;
            end
            ptw_pkg::ST_SCAN: begin
                if (rd_idx_reg == IDX_TOP) begin
                    state_next = ptw_pkg::ST_DRAIN;
                end
            end
            ptw_pkg::ST_DRAIN: begin
                state_next = ptw_pkg::ST_EMIT;
            end
            ptw_pkg::ST_EMIT: begin
                if (fired_reg == '0) begin
                    if (out_free) begin
                        state_next = ptw_pkg::ST_IDLE;
                    end
                end else if (fired_reg[emit_idx_reg] && out_free && emit_last) begin
                    state_next = ptw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        valid_next    = valid_reg;
        pos_next      = pos_reg;
        id_next       = id_reg;
        div_x_next    = div_x_reg;
        div_q_next    = div_q_reg;
        rd_idx_next   = rd_idx_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = rd_idx_reg;
        fired_next    = fired_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_addr       = pipe_idx_reg;
        wr_entry      = rd_entry;

        unique case (state_reg)
            ptw_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_action)
                        ptw_pkg::ACT_ADD: begin
                            id_next    = s_timer_id;
                            div_x_next = (p_in == '0) ? '0 : p_in - PERIOD_BITS'(1);
                        end
                        ptw_pkg::ACT_DEL: begin
                            m_valid_next = 1'b1;
                            m_id_next    = s_timer_id;
                            m_last_next  = 1'b1;
                            if (id_ok && valid_reg[IDX_BITS'(s_timer_id)]) begin
                                valid_next[IDX_BITS'(s_timer_id)] = 1'b0;
                                m_kind_next = ptw_pkg::KIND_DELETED;
                            end else begin
                                m_kind_next = ptw_pkg::KIND_DEL_MISS;
                            end
                        end
                        ptw_pkg::ACT_TICK: begin
                            pos_next      = (pos_reg == SLOT_TOP) ? '0 : pos_reg + SLOT_BITS'(1);
                            rd_idx_next   = '0;
                            emit_idx_next = '0;
                            fired_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ptw_pkg::ST_DIV: begin
                div_q_next = div_prod[RECIP_SHIFT +: ROUND_BITS];
            end
            ptw_pkg::ST_ADD_WR: begin
                wr_en           = 1'b1;
                wr_addr         = IDX_BITS'(id_reg);
                wr_entry.offset = add_offset;
                wr_entry.reload = div_q_reg;
                wr_entry.rounds = div_q_reg;
                wr_entry.slot   = slot_after(pos_reg, add_offset);
                valid_next[IDX_BITS'(id_reg)] = 1'b1;
                m_valid_next = 1'b1;
                m_kind_next  = ptw_pkg::KIND_ADDED;
                m_id_next    = id_reg;
                m_last_next  = 1'b1;
            end
            ptw_pkg::ST_SCAN: begin
                pipe_vld_next = 1'b1;
                rd_idx_next   = rd_idx_reg + IDX_BITS'(1);
            end
            ptw_pkg::ST_DRAIN: begin
            end
            ptw_pkg::ST_EMIT: begin
                if (fired_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = ptw_pkg::KIND_IDLE_TICK;
                        m_id_next    = '0;
                        m_last_next  = 1'b1;
                    end
                end else if (fired_reg[emit_idx_reg]) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_kind_next   = ptw_pkg::KIND_FIRED;
                        m_id_next     = ptw_pkg::ID_BITS'(emit_idx_reg);
                        m_last_next   = emit_last;
                        fired_next    = fired_rest;
                        emit_idx_next = emit_idx_reg + IDX_BITS'(1);
                    end
                end else begin
                    emit_idx_next = emit_idx_reg + IDX_BITS'(1);
                end
            end
            default: begin
            end
        endcase

        // Write-back stage of the scan: the entry read last cycle is due or counts down.
        if (hit) begin
            wr_en   = 1'b1;
            wr_addr = pipe_idx_reg;
            if (rd_entry.rounds == '0) begin
                wr_entry.rounds = rd_entry.reload;
                wr_entry.slot   = slot_after(pos_reg, rd_entry.offset);
                fired_next[pipe_idx_reg] = 1'b1;
            end else begin
                wr_entry.rounds = rd_entry.rounds - ROUND_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ptw_pkg::ST_IDLE;
            valid_reg    <= '0;
            pos_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            pos_reg      <= pos_next;
            pipe_vld_reg <= pipe_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        div_x_reg    <= div_x_next;
        div_q_reg    <= div_q_next;
        rd_idx_reg   <= rd_idx_next;
        pipe_idx_reg <= pipe_idx_next;
        fired_reg    <= fired_next;
        emit_idx_reg <= emit_idx_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_timer_id_res = m_id_reg;
    assign m_last         = m_last_reg;

endmodule
